FILE: sv/piecewise_linear_position_predictor_defines.svh
`ifndef PIECEWISE_LINEAR_POSITION_PREDICTOR_DEFINES_SVH
`define PIECEWISE_LINEAR_POSITION_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plpp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plpp: next-cycle check failed");

`endif

FILE: sv/plpp_pkg.sv
`timescale 1ns / 1ps

package plpp_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int MIN_SEGMENTS = 2;
    localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);

    localparam int SLOPE_FRAC_BITS     = 32;
    localparam int INTERCEPT_FRAC_BITS = 16;
    localparam int ERROR_FRAC_BITS     = 16;

    // Field widths.
    localparam int KEY_W    = 64;
    localparam int SLOT_W   = 10;
    localparam int SLOPE_W  = 64;
    localparam int ICP_W    = 64;
    localparam int POS_W    = 32;
    localparam int ERR_W    = 24;
    localparam int SEGCNT_W = 11;
    localparam int HALF_W   = 32;
    localparam int PROD_W   = 2 * KEY_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Input payload layout, first field in the lowest bits.
    localparam int KEY_LSB     = 0;
    localparam int SLOT_LSB    = KEY_LSB + KEY_W;
    localparam int SLOPE_LSB   = SLOT_LSB + SLOT_W;
    localparam int ICP_LSB     = SLOPE_LSB + SLOPE_W;
    localparam int IN_FIELDS_W = ICP_LSB + ICP_W;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * POS_W + 7) / 8) * 8;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Working fixed-point format: one fraction bit beyond the finest input so
    // that halving the prediction stays exact.
    localparam int WORK_FRAC = imax(imax(SLOPE_FRAC_BITS, INTERCEPT_FRAC_BITS),
                                    ERROR_FRAC_BITS) + 1;
    localparam int P_SHIFT   = WORK_FRAC - SLOPE_FRAC_BITS;
    localparam int I_SHIFT   = WORK_FRAC - INTERCEPT_FRAC_BITS;
    localparam int E_SHIFT   = WORK_FRAC - ERROR_FRAC_BITS;
    localparam int WORK_W    = imax(imax(PROD_W + P_SHIFT, ICP_W + I_SHIFT),
                                    ERR_W + E_SHIFT) + 3;
    localparam int INT_W     = WORK_W - WORK_FRAC;

    localparam int MUL_STEPS = 4;
    localparam int CNT_W     = 3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWEST_KEY,
        CFG_HIGHEST_KEY,
        CFG_ENTRY_COUNT,
        CFG_ERROR_BOUND,
        CFG_HALVE,
        CFG_SEGMENT_COUNT
    } plpp_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_SRCH,
        ST_FETCH,
        ST_MAG,
        ST_MUL,
        ST_NEG,
        ST_PRED,
        ST_LOW,
        ST_UP,
        ST_FIN
    } plpp_state_t;

endpackage

FILE: sv/plpp_ram.sv
`timescale 1ns / 1ps

module plpp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/piecewise_linear_position_predictor.sv
// Segment writes can arrive back to back. A lookup inside the key range searches the
// key table with P probes, where P = ceil(log2(segment_count - 1)) for the clamped
// segment count, one key-table read per probe, then a shared 32x32 multiplier and one
// shared adder set the rest. A range miss skips the search and the arithmetic. The block
// takes its next item only once the result has been loaded into the output register.
// Reset clears control and configuration registers; the segment tables keep no reset.
`timescale 1ns / 1ps
`include "piecewise_linear_position_predictor_defines.svh"

module piecewise_linear_position_predictor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [plpp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plpp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key[63:0], entry_slot[73:64], slope[137:74], intercept[201:138], zero pad
    input  logic [plpp_pkg::S_TDATA_W-1:0]   s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // lower_position[31:0], upper_position[63:32]
    output logic [plpp_pkg::M_TDATA_W-1:0]   m_tdata,
    // hit
    output logic                             m_tuser
);

    localparam int KEY_W     = plpp_pkg::KEY_W;
    localparam int SLOPE_W   = plpp_pkg::SLOPE_W;
    localparam int ICP_W     = plpp_pkg::ICP_W;
    localparam int POS_W     = plpp_pkg::POS_W;
    localparam int HALF_W    = plpp_pkg::HALF_W;
    localparam int WORK_W    = plpp_pkg::WORK_W;
    localparam int WORK_FRAC = plpp_pkg::WORK_FRAC;
    localparam int INT_W     = plpp_pkg::INT_W;
    localparam int IDX_W     = plpp_pkg::SEG_IDX_W;
    localparam int CNT_W     = plpp_pkg::CNT_W;

    // Configuration registers.
    logic [KEY_W-1:0]              lowest_key_reg;
    logic [KEY_W-1:0]              highest_key_reg;
    logic [POS_W-1:0]              entry_count_reg;
    logic [plpp_pkg::ERR_W-1:0]    error_bound_reg;
    logic                          halve_reg;
    logic [plpp_pkg::SEGCNT_W-1:0] segment_count_reg;

    // Control state.
    plpp_pkg::plpp_state_t state_reg, state_next;
    logic [IDX_W-1:0]      left_reg, left_next;
    logic [IDX_W-1:0]      right_reg, right_next;
    logic [IDX_W-1:0]      mid_reg, mid_next;
    logic [IDX_W:0]        mid_sum;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  miss_reg, miss_next;
    logic                  m_tvalid_reg;

    // Datapath registers.
    logic [KEY_W-1:0]   key_reg;
    logic [SLOPE_W-1:0] slope_reg;
    logic [ICP_W-1:0]   icp_reg;
    logic [KEY_W-1:0]   mag_reg, mag_next;
    logic [WORK_W-1:0]  acc_reg, acc_next;
    logic [WORK_W-1:0]  lo_reg, lo_next;
    logic [PROD_W_L-1:0] pp_reg;
    logic [1:0]         pp_sh_reg;
    logic [POS_W-1:0]   lower_out_reg;
    logic [POS_W-1:0]   upper_out_reg;
    logic               hit_out_reg;

    localparam int PROD_W_L = 2 * HALF_W;

    // Input fields.
    logic [KEY_W-1:0]                in_key;
    logic [plpp_pkg::SLOT_W-1:0]     in_slot;
    logic [SLOPE_W-1:0]              in_slope;
    logic [ICP_W-1:0]                in_icp;
    logic                            accept;
    logic                            wr_en;

    // Memory read data.
    logic [KEY_W-1:0]         key_rdata;
    logic [ICP_W+SLOPE_W-1:0] coef_rdata;

    // Shared adder.
    logic [WORK_W-1:0] alu_a, alu_b, alu_res;
    logic              alu_sub;

    // Multiplier.
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [PROD_W_L-1:0] mul_p;

    // Right end of the search, from the clamped segment count.
    logic [IDX_W-1:0] right_init;
    logic             key_out;

    // Result evaluation.
    logic [WORK_W-1:0] err_ext;
    logic [WORK_W-1:0] icp_ext;
    logic [WORK_W-1:0] pp_shifted;
    logic [INT_W-1:0]  lo_int, up_int;
    logic              lo_neg, up_neg, lo_ge, up_ge, up_frac;
    logic [POS_W:0]    up_ceil;
    logic [POS_W-1:0]  ec_m1, res_lower, res_upper;
    logic              res_miss;
    logic              out_load;

    assign in_key   = s_tdata[plpp_pkg::KEY_LSB +: KEY_W];
    assign in_slot  = s_tdata[plpp_pkg::SLOT_LSB +: plpp_pkg::SLOT_W];
    assign in_slope = s_tdata[plpp_pkg::SLOPE_LSB +: SLOPE_W];
    assign in_icp   = s_tdata[plpp_pkg::ICP_LSB +: ICP_W];

    assign s_tready = (state_reg == plpp_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == plpp_pkg::OP_WRITE)
                      && (32'(in_slot) < 32'(plpp_pkg::MAX_SEGMENTS));

    plpp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (plpp_pkg::MAX_SEGMENTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (IDX_W'(in_slot)),
        .wdata (in_key),
        .raddr (mid_next),
        .rdata (key_rdata)
    );

    plpp_ram #(
        .WIDTH (ICP_W + SLOPE_W),
        .DEPTH (plpp_pkg::MAX_SEGMENTS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (IDX_W'(in_slot)),
        .wdata ({in_icp, in_slope}),
        .raddr (left_next),
        .rdata (coef_rdata)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_key_reg    <= '0;
            highest_key_reg   <= '0;
            entry_count_reg   <= '0;
            error_bound_reg   <= '0;
            halve_reg         <= 1'b0;
            segment_count_reg <= plpp_pkg::SEGCNT_W'(plpp_pkg::MIN_SEGMENTS);
        end
        else if (cfg_we)
        begin
            case (plpp_pkg::plpp_cfg_idx_t'(cfg_index))
                plpp_pkg::CFG_LOWEST_KEY:    lowest_key_reg  <= cfg_data[KEY_W-1:0];
                plpp_pkg::CFG_HIGHEST_KEY:   highest_key_reg <= cfg_data[KEY_W-1:0];
                plpp_pkg::CFG_ENTRY_COUNT:   entry_count_reg <= cfg_data[POS_W-1:0];
                plpp_pkg::CFG_ERROR_BOUND:
                    error_bound_reg <= cfg_data[plpp_pkg::ERR_W-1:0];
                plpp_pkg::CFG_HALVE:         halve_reg       <= cfg_data[0];
                plpp_pkg::CFG_SEGMENT_COUNT:
                    segment_count_reg <= cfg_data[plpp_pkg::SEGCNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (32'(segment_count_reg) < 32'(plpp_pkg::MIN_SEGMENTS))
        begin
            right_init = IDX_W'(plpp_pkg::MIN_SEGMENTS - 1);
        end
        else if (32'(segment_count_reg) > 32'(plpp_pkg::MAX_SEGMENTS))
        begin
            right_init = IDX_W'(plpp_pkg::MAX_SEGMENTS - 1);
        end
        else
        begin
            right_init = IDX_W'(segment_count_reg - 1'b1);
        end
    end

    assign key_out = (key_reg > highest_key_reg) || (key_reg < lowest_key_reg);

    assign mid_sum  = {1'b0, left_next} + {1'b0, right_next};
    assign mid_next = mid_sum[IDX_W:1];

    // The 32x32 partial products are taken in the order low*low, low*high,
    // high*low, high*high; the step count selects the halves.
    assign mul_a = cnt_reg[1] ? key_reg[KEY_W-1:HALF_W] : key_reg[HALF_W-1:0];
    assign mul_b = cnt_reg[0] ? mag_reg[KEY_W-1:HALF_W] : mag_reg[HALF_W-1:0];
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_shifted = WORK_W'(pp_reg);
            2'd1:    pp_shifted = WORK_W'(pp_reg) << HALF_W;
            2'd2:    pp_shifted = WORK_W'(pp_reg) << (2 * HALF_W);
            default: pp_shifted = '0;
        endcase
    end

    assign err_ext = WORK_W'(error_bound_reg) << plpp_pkg::E_SHIFT;
    assign icp_ext = {{(WORK_W - ICP_W){icp_reg[ICP_W-1]}}, icp_reg};

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + WORK_W'(alu_sub);

    // Bounds: lower bound sits in lo_reg, upper bound in acc_reg.
    assign lo_neg = lo_reg[WORK_W-1];
    assign lo_int = lo_reg[WORK_W-1:WORK_FRAC];
    assign lo_ge  = (|lo_int[INT_W-1:POS_W]) || (lo_int[POS_W-1:0] >= entry_count_reg);
    assign up_neg = acc_reg[WORK_W-1];
    assign up_int = acc_reg[WORK_W-1:WORK_FRAC];
    assign up_ge  = (|up_int[INT_W-1:POS_W]) || (up_int[POS_W-1:0] >= entry_count_reg);
    assign up_frac = |acc_reg[WORK_FRAC-1:0];
    assign up_ceil = {1'b0, up_int[POS_W-1:0]} + (POS_W + 1)'(up_frac);
    assign ec_m1   = entry_count_reg - 1'b1;

    assign res_miss  = miss_reg || (entry_count_reg == '0) || (!lo_neg && lo_ge);
    assign res_lower = lo_neg ? '0 : lo_int[POS_W-1:0];

    always_comb
    begin
        if (up_neg)
        begin
            res_upper = '0;
        end
        else if (up_ge || (up_ceil >= {1'b0, entry_count_reg}))
        begin
            res_upper = ec_m1;
        end
        else
        begin
            res_upper = up_ceil[POS_W-1:0];
        end
    end

    // Sequencer and shared adder operand selection.
    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        right_next = right_reg;
        cnt_next   = cnt_reg;
        miss_next  = miss_reg;
        mag_next   = mag_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            plpp_pkg::ST_IDLE:
            begin
                if (accept && (s_tuser == plpp_pkg::OP_LOOKUP))
                begin
                    state_next = plpp_pkg::ST_RANGE;
                end
            end

            plpp_pkg::ST_RANGE:
            begin
                left_next  = '0;
                right_next = right_init;
                miss_next  = key_out;
                if (key_out)
                begin
                    state_next = plpp_pkg::ST_FIN;
                end
                else if (right_init == IDX_W'(1))
                begin
                    state_next = plpp_pkg::ST_FETCH;
                end
                else
                begin
                    state_next = plpp_pkg::ST_SRCH;
                end
            end

            plpp_pkg::ST_SRCH:
            begin
                if (key_reg < key_rdata)
                begin
                    right_next = mid_reg;
                end
                else
                begin
                    left_next = mid_reg;
                end
                if (({1'b0, left_next} + 1'b1) == {1'b0, right_next})
                begin
                    state_next = plpp_pkg::ST_FETCH;
                end
            end

            plpp_pkg::ST_FETCH:
            begin
                state_next = plpp_pkg::ST_MAG;
            end

            plpp_pkg::ST_MAG:
            begin
                alu_b      = {{(WORK_W - SLOPE_W){slope_reg[SLOPE_W-1]}}, slope_reg};
                alu_sub    = slope_reg[SLOPE_W-1];
                mag_next   = alu_res[KEY_W-1:0];
                acc_next   = '0;
                cnt_next   = '0;
                state_next = plpp_pkg::ST_MUL;
            end

            plpp_pkg::ST_MUL:
            begin
                alu_a    = acc_reg;
                alu_b    = pp_shifted;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    acc_next = alu_res;
                end
                if (cnt_reg == CNT_W'(plpp_pkg::MUL_STEPS))
                begin
                    state_next = plpp_pkg::ST_NEG;
                end
            end

            plpp_pkg::ST_NEG:
            begin
                alu_b   = acc_reg;
                alu_sub = 1'b1;
                if (slope_reg[SLOPE_W-1])
                begin
                    acc_next = alu_res;
                end
                state_next = plpp_pkg::ST_PRED;
            end

            plpp_pkg::ST_PRED:
            begin
                if (halve_reg)
                begin
                    alu_a = acc_reg << (plpp_pkg::P_SHIFT - 1);
                    alu_b = icp_ext << (plpp_pkg::I_SHIFT - 1);
                end
                else
                begin
                    alu_a = acc_reg << plpp_pkg::P_SHIFT;
                    alu_b = icp_ext << plpp_pkg::I_SHIFT;
                end
                acc_next   = alu_res;
                state_next = plpp_pkg::ST_LOW;
            end

            plpp_pkg::ST_LOW:
            begin
                alu_a      = acc_reg;
                alu_b      = err_ext;
                alu_sub    = 1'b1;
                lo_next    = alu_res;
                state_next = plpp_pkg::ST_UP;
            end

            plpp_pkg::ST_UP:
            begin
                alu_a      = acc_reg;
                alu_b      = err_ext;
                acc_next   = alu_res;
                state_next = plpp_pkg::ST_FIN;
            end

            plpp_pkg::ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = plpp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = plpp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= plpp_pkg::ST_IDLE;
            left_reg     <= '0;
            right_reg    <= '0;
            mid_reg      <= '0;
            cnt_reg      <= '0;
            miss_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            mid_reg   <= mid_next;
            cnt_reg   <= cnt_next;
            miss_reg  <= miss_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= in_key;
        end
        if (state_reg == plpp_pkg::ST_FETCH)
        begin
            slope_reg <= coef_rdata[SLOPE_W-1:0];
            icp_reg   <= coef_rdata[ICP_W+SLOPE_W-1:SLOPE_W];
        end
        if ((state_reg == plpp_pkg::ST_MUL) && (cnt_reg < CNT_W'(plpp_pkg::MUL_STEPS)))
        begin
            pp_reg    <= mul_p;
            pp_sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
        end
        mag_reg <= mag_next;
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        if (out_load)
        begin
            hit_out_reg   <= !res_miss;
            lower_out_reg <= res_miss ? entry_count_reg : res_lower;
            upper_out_reg <= res_miss ? entry_count_reg : res_upper;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_out_reg;
    assign m_tdata  = plpp_pkg::M_TDATA_W'({upper_out_reg, lower_out_reg});

    `PLPP_ASSERT_NEXT(a_lookup_holds_off, clk, rst_n, s_tvalid && s_tready && (s_tuser == plpp_pkg::OP_LOOKUP), !s_tready)
    `PLPP_ASSERT_IMPLY(a_search_ordered, clk, rst_n, state_reg == plpp_pkg::ST_SRCH, left_reg < right_reg)
    `PLPP_ASSERT_IMPLY(a_mul_steps, clk, rst_n, state_reg == plpp_pkg::ST_MUL, cnt_reg <= CNT_W'(plpp_pkg::MUL_STEPS))
    `PLPP_ASSERT_IMPLY(a_result_from_fin, clk, rst_n, $rose(m_tvalid), $past(state_reg) == plpp_pkg::ST_FIN)
    `PLPP_ASSERT_IMPLY(a_hit_interval, clk, rst_n, m_tvalid && m_tuser, m_tdata[POS_W-1:0] <= m_tdata[2*POS_W-1:POS_W])

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import plpp_pkg::*;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [9:0]  slot;
        logic [63:0] slope;
        logic [63:0] icp;
    } seg_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] lower;
        logic [31:0] upper;
    } pos_result_t;

    typedef struct packed {
        logic          is_reg;
        plpp_cfg_idx_t reg_idx;
        logic [63:0]   reg_val;
        seg_req_t      req;
        logic          known;
        pos_result_t   want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    // Local copy of the segment table and of the configuration registers.
    logic [63:0] seg_start [MAX_SEGMENTS];
    logic [63:0] seg_slope [MAX_SEGMENTS];
    logic [63:0] seg_icp   [MAX_SEGMENTS];
    logic [63:0] lowest_r;
    logic [63:0] highest_r;
    logic [31:0] entry_count_r;
    logic [23:0] err_bound_r;
    logic        halve_r;
    logic [10:0] seg_count_r;

    pos_result_t pending_positions[$];
    int          n_errors;
    bit          burst_phase;
    bit          busy;
    dir_row_t    dir_rows[$];

    piecewise_linear_position_predictor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected interval for a key, worked out in a 192-bit format with 64
    // fraction bits, wide enough that nothing can overflow.
    function automatic pos_result_t predict_position(input logic [63:0] key);
        pos_result_t       res;
        int                n;
        int                left;
        int                right;
        int                mid;
        logic signed [191:0] k_ext;
        logic signed [191:0] s_ext;
        logic signed [191:0] i_ext;
        logic signed [191:0] pred;
        logic signed [191:0] err;
        logic signed [191:0] lo;
        logic signed [191:0] up;
        logic [63:0]       lower;
        logic [63:0]       upper;
        res.hit   = 1'b0;
        res.lower = entry_count_r;
        res.upper = entry_count_r;
        if (key > highest_r || key < lowest_r)
            return res;
        n = seg_count_r;
        if (n < 2)
            n = 2;
        if (n > MAX_SEGMENTS)
            n = MAX_SEGMENTS;
        left  = 0;
        right = n - 1;
        while (left != right - 1)
        begin
            mid = (left + right) / 2;
            if (key < seg_start[mid])
                right = mid;
            else
                left = mid;
        end
        k_ext = {128'd0, key};
        s_ext = {{128{seg_slope[left][63]}}, seg_slope[left]};
        i_ext = {{128{seg_icp[left][63]}}, seg_icp[left]};
        pred  = ((k_ext * s_ext) <<< 32) + (i_ext <<< 48);
        if (halve_r)
            pred = pred >>> 1;
        err = {120'd0, err_bound_r, 48'd0};
        lo  = pred - err;
        if (lo[191])
            lower = 64'd0;
        else
        begin
            if (lo[191:128] != 64'd0 || lo[127:64] >= {32'd0, entry_count_r})
                return res;
            lower = lo[127:64];
        end
        if (lower >= {32'd0, entry_count_r})
            return res;
        up = pred + err;
        if (up[191])
            upper = 64'd0;
        else if (up[191:128] != 64'd0 || up[127:64] >= {32'd0, entry_count_r})
            upper = {32'd0, entry_count_r} - 64'd1;
        else
        begin
            upper = up[127:64] + ((up[63:0] != 64'd0) ? 64'd1 : 64'd0);
            if (upper >= {32'd0, entry_count_r})
                upper = {32'd0, entry_count_r} - 64'd1;
        end
        res.hit   = 1'b1;
        res.lower = lower[31:0];
        res.upper = upper[31:0];
        return res;
    endfunction

    // A segment that maps keys near slot * 2^32 onto positions near slot * 2048.
    function automatic seg_req_t make_segment(input int slot);
        seg_req_t    r;
        logic [63:0] pos;
        logic [63:0] tilt;
        r.op    = OP_WRITE;
        r.slot  = slot[9:0];
        r.key   = {22'd0, slot[9:0], 1'b0, 31'($urandom)};
        r.slope = 64'($urandom_range(0, 4095));
        pos     = 64'(slot) * 64'd2048 + 64'($urandom_range(0, 2047));
        tilt    = r.slope * r.key;
        r.icp   = (pos << 16) - (tilt >> 16) + 64'($urandom_range(0, 65535));
        return r;
    endfunction

    function automatic dir_row_t reg_row(input plpp_cfg_idx_t idx, input logic [63:0] val);
        dir_row_t row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic dir_row_t wr_row(input logic [63:0] key, input logic [9:0] slot,
                                        input logic [63:0] slope, input logic [63:0] icp);
        dir_row_t row;
        row     = '0;
        row.req = '{OP_WRITE, key, slot, slope, icp};
        return row;
    endfunction

    function automatic dir_row_t lk_row(input logic [63:0] key, input logic known,
                                        input logic hit, input logic [31:0] lower,
                                        input logic [31:0] upper);
        dir_row_t row;
        row       = '0;
        row.req   = '{OP_LOOKUP, key, 10'd0, 64'd0, 64'd0};
        row.known = known;
        row.want  = '{hit, lower, upper};
        return row;
    endfunction

    task automatic send_req(input seg_req_t req, input logic known, input pos_result_t want);
        int gap;
        gap = burst_phase ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({req.icp, req.slope, req.slot, req.key});
        s_tuser  <= req.op;
        do @(posedge clk); while (s_tready !== 1'b1);
        busy = 1'b1;
        if (req.op == OP_WRITE)
        begin
            seg_start[req.slot] = req.key;
            seg_slope[req.slot] = req.slope;
            seg_icp[req.slot]   = req.icp;
        end
        else
            pending_positions.push_back(known ? want : predict_position(req.key));
    endtask

    // Stop sending and let the block finish whatever it still works on.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        busy = 1'b0;
    endtask

    task automatic write_reg(input plpp_cfg_idx_t idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LOWEST_KEY:    lowest_r      = val;
            CFG_HIGHEST_KEY:   highest_r     = val;
            CFG_ENTRY_COUNT:   entry_count_r = val[31:0];
            CFG_ERROR_BOUND:   err_bound_r   = val[23:0];
            CFG_HALVE:         halve_r       = val[0];
            CFG_SEGMENT_COUNT: seg_count_r   = val[10:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_result(input pos_result_t got);
        pos_result_t want;
        if (pending_positions.size() == 0)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("unexpected result: hit=%0d lower=%0d upper=%0d",
                         got.hit, got.lower, got.upper);
            return;
        end
        want = pending_positions.pop_front();
        if (got.hit !== want.hit || got.lower !== want.lower || got.upper !== want.upper)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch: expected hit=%0d lower=%0d upper=%0d, got hit=%0d lower=%0d upper=%0d",
                         want.hit, want.lower, want.upper, got.hit, got.lower, got.upper);
        end
    endtask

    // Result side: random stall before every transfer.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = burst_phase ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            check_result('{m_tuser, m_tdata[31:0], m_tdata[63:32]});
        end
    end

    initial
    begin
        #5_000_000;
        $display("** piecewise_linear_position_predictor: FAILED **");
        $finish;
    end

    initial
    begin
        dir_row_t    row;
        seg_req_t    req;
        pos_result_t none;
        int          rand_items;
        int          p;
        int          k;
        int          r;
        int          phase_len;
        logic [63:0] lo_v;
        logic [63:0] hi_v;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_LOWEST_KEY;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_WRITE;
        n_errors      = 0;
        burst_phase   = 1'b0;
        busy          = 1'b0;
        none          = '0;
        lowest_r      = '0;
        highest_r     = '0;
        entry_count_r = '0;
        err_bound_r   = '0;
        halve_r       = 1'b0;
        seg_count_r   = 11'd2;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. After reset only key 0 is in range, so the first lookup misses.
        dir_rows.push_back(lk_row(64'd5, 1'b1, 1'b0, 32'd0, 32'd0));
        dir_rows.push_back(wr_row(64'd0, 10'd0, 64'd0, 64'd10 << 16));
        dir_rows.push_back(wr_row('1, 10'd1, 64'd0, 64'd0));
        dir_rows.push_back(wr_row('1, 10'd1023, '1, '1));
        dir_rows.push_back(reg_row(CFG_HIGHEST_KEY, '1));
        dir_rows.push_back(reg_row(CFG_ENTRY_COUNT, 64'd100));
        dir_rows.push_back(lk_row(64'd0, 1'b1, 1'b1, 32'd10, 32'd10));
        dir_rows.push_back(lk_row('1, 1'b1, 1'b1, 32'd10, 32'd10));
        // With no positions every lookup misses.
        dir_rows.push_back(reg_row(CFG_ENTRY_COUNT, 64'd0));
        dir_rows.push_back(lk_row(64'd7, 1'b1, 1'b0, 32'd0, 32'd0));
        dir_rows.push_back(reg_row(CFG_ENTRY_COUNT, 64'd100));
        dir_rows.push_back(reg_row(CFG_ERROR_BOUND, 64'h18000));
        dir_rows.push_back(reg_row(CFG_HALVE, 64'd1));
        dir_rows.push_back(wr_row(64'd0, 10'd0, 64'd1 << 32, 64'd0));
        dir_rows.push_back(lk_row(64'd20, 1'b1, 1'b1, 32'd8, 32'd12));
        dir_rows.push_back(lk_row(64'd21, 1'b1, 1'b1, 32'd9, 32'd12));
        dir_rows.push_back(reg_row(CFG_HALVE, 64'd0));
        dir_rows.push_back(reg_row(CFG_ERROR_BOUND, 64'hFF_FFFF));
        dir_rows.push_back(lk_row(64'd50, 1'b1, 1'b1, 32'd0, 32'd99));
        dir_rows.push_back(wr_row(64'd0, 10'd0, -(64'd1 << 32), 64'd0));
        dir_rows.push_back(lk_row(64'd1000, 1'b1, 1'b1, 32'd0, 32'd0));
        dir_rows.push_back(reg_row(CFG_ERROR_BOUND, 64'd0));
        dir_rows.push_back(wr_row(64'd0, 10'd0, 64'h7FFF_FFFF_FFFF_FFFF,
                                  64'h8000_0000_0000_0000));
        dir_rows.push_back(lk_row('1, 1'b0, 1'b0, 32'd0, 32'd0));
        dir_rows.push_back(wr_row(64'd0, 10'd0, 64'h8000_0000_0000_0000,
                                  64'h7FFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(lk_row('1, 1'b0, 1'b0, 32'd0, 32'd0));
        // Crossed range registers: nothing can hit.
        dir_rows.push_back(reg_row(CFG_LOWEST_KEY, 64'd100));
        dir_rows.push_back(reg_row(CFG_HIGHEST_KEY, 64'd50));
        dir_rows.push_back(lk_row(64'd75, 1'b1, 1'b0, 32'd100, 32'd100));
        dir_rows.push_back(reg_row(CFG_HIGHEST_KEY, 64'd200));
        dir_rows.push_back(lk_row(64'd99, 1'b1, 1'b0, 32'd100, 32'd100));
        dir_rows.push_back(lk_row(64'd201, 1'b1, 1'b0, 32'd100, 32'd100));
        dir_rows.push_back(lk_row(64'd100, 1'b0, 1'b0, 32'd0, 32'd0));
        // Lower bound landing exactly on the entry count misses.
        dir_rows.push_back(wr_row(64'd0, 10'd0, 64'd0, 64'd100 << 16));
        dir_rows.push_back(lk_row(64'd150, 1'b1, 1'b0, 32'd100, 32'd100));
        // 99.5 rounds up to 100 and is then clamped to the last position.
        dir_rows.push_back(wr_row(64'd0, 10'd0, 64'd0, 64'd6520832));
        dir_rows.push_back(lk_row(64'd150, 1'b1, 1'b1, 32'd99, 32'd99));
        dir_rows.push_back(reg_row(CFG_SEGMENT_COUNT, 64'd0));
        dir_rows.push_back(lk_row(64'd200, 1'b0, 1'b0, 32'd0, 32'd0));

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_reg)
            begin
                if (busy)
                    settle();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
                send_req(row.req, row.known, row.want);
        end

        // Build a full, sorted table so that every segment count is legal afterwards.
        rand_items = 0;
        for (k = 0; k < MAX_SEGMENTS; k++)
        begin
            burst_phase = (k >= 400 && k < 600);
            send_req(make_segment(k), 1'b0, none);
            rand_items++;
        end

        p = 0;
        while (rand_items < 1650)
        begin
            settle();
            burst_phase = (p % 5 == 2);
            case (p % 4)
                0:
                begin
                    lo_v = 64'd0;
                    hi_v = '1;
                end
                1:
                begin
                    lo_v = 64'($urandom_range(0, 300)) << 32;
                    hi_v = lo_v + (64'($urandom_range(1, 700)) << 32);
                end
                2:
                begin
                    lo_v = (p % 8 == 2) ? (64'd1 << 41) : 64'd0;
                    hi_v = (p % 8 == 2) ? (64'd1 << 40) : ((64'd1 << 42) - 64'd1);
                end
                default:
                begin
                    lo_v = (p % 8 == 7) ? '1 : {32'd0, $urandom};
                    hi_v = '1;
                end
            endcase
            write_reg(CFG_LOWEST_KEY, lo_v);
            write_reg(CFG_HIGHEST_KEY, hi_v);
            case (p % 7)
                3:       write_reg(CFG_ENTRY_COUNT, 64'd0);
                5:       write_reg(CFG_ENTRY_COUNT, 64'hFFFF_FFFF);
                6:       write_reg(CFG_ENTRY_COUNT, 64'($urandom_range(1, 64)));
                default: write_reg(CFG_ENTRY_COUNT, 64'($urandom_range(1000000, 2500000)));
            endcase
            case (p % 3)
                0:       write_reg(CFG_ERROR_BOUND, 64'd0);
                1:       write_reg(CFG_ERROR_BOUND, 64'hFF_FFFF);
                default: write_reg(CFG_ERROR_BOUND, 64'($urandom_range(0, 24'hFF_FFFF)));
            endcase
            write_reg(CFG_HALVE, (p < 2) ? 64'(p) : 64'($urandom_range(0, 1)));
            case (p % 6)
                0:       write_reg(CFG_SEGMENT_COUNT, 64'd1024);
                1:       write_reg(CFG_SEGMENT_COUNT, 64'd2047);
                2:       write_reg(CFG_SEGMENT_COUNT, 64'd0);
                3:       write_reg(CFG_SEGMENT_COUNT, 64'd1);
                4:       write_reg(CFG_SEGMENT_COUNT, 64'd2);
                default: write_reg(CFG_SEGMENT_COUNT, 64'($urandom_range(3, 1024)));
            endcase

            phase_len = $urandom_range(30, 50);
            for (k = 0; k < phase_len; k++)
            begin
                r   = $urandom_range(0, 99);
                req = '{OP_LOOKUP, {22'd0, 10'($urandom), $urandom}, 10'($urandom),
                        64'd0, 64'd0};
                if (r < 60)
                    ;
                else if (r < 68)
                    req.key = {$urandom, $urandom};
                else if (r < 75)
                begin
                    case ($urandom_range(0, 3))
                        0:       req.key = lowest_r;
                        1:       req.key = highest_r;
                        2:       req.key = highest_r + 64'd1;
                        default: req.key = lowest_r - 64'd1;
                    endcase
                end
                else if (r < 90)
                    req = make_segment($urandom_range(0, MAX_SEGMENTS - 1));
                else
                    req = '{OP_WRITE, {$urandom, $urandom}, 10'($urandom),
                            {$urandom, $urandom}, {$urandom, $urandom}};
                send_req(req, 1'b0, none);
                rand_items++;
            end
            p++;
        end

        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_errors == 0 && pending_positions.size() == 0)
            $display("** piecewise_linear_position_predictor: PASSED **");
        else
            $display("** piecewise_linear_position_predictor: FAILED **");
        $finish;
    end

endmodule
